@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros used by the transcoder back end
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the module's own clock and reset
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Concurrent check on an explicit clock and active-low reset
`define ASSERT_RST_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

`endif

@@ design/u16u8_pkg.sv @@
// ---------------------------------------------------------------------------
// u16u8_pkg
// Types, constants and byte-building helpers for the UTF-16 to UTF-8
// transcoder.
// ---------------------------------------------------------------------------
package u16u8_pkg;

  // Default depth of the job queue between front and back
  localparam int unsigned QueueDepth = 4;

  // Register map
  localparam int unsigned RegIdxW = 1;
  typedef enum logic [RegIdxW-1:0] {
    REG_STRICT_MODE     = 1'b0,
    REG_OUTPUT_CAPACITY = 1'b1
  } reg_idx_e;

  localparam logic        StrictReset   = 1'b0;
  localparam logic [15:0] CapacityReset = 16'hFFFF;

  // Error codes on a result beat
  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_INVALID = 2'd1,
    ERR_TRUNC   = 2'd2,
    ERR_FULL    = 2'd3
  } err_e;

  // Surrogate tags are the top six bits of a code unit
  localparam logic [5:0]  HighSurrTag = 6'b110110;  // D800..DBFF
  localparam logic [5:0]  LowSurrTag  = 6'b110111;  // DC00..DFFF
  localparam logic [20:0] SuppBase    = 21'h10000;

  // UTF-8 lead and continuation marks
  localparam logic [7:0] Lead2Mark = 8'hC0;
  localparam logic [7:0] Lead3Mark = 8'hE0;
  localparam logic [7:0] Lead4Mark = 8'hF0;
  localparam logic [7:0] ContMark  = 8'h80;

  // Configuration as seen by the front
  typedef struct packed {
    logic        strict;
    logic [15:0] capacity;
  } cfg_t;

  // One output segment: a code point to encode, or an error beat
  typedef struct packed {
    logic        is_err;
    err_e        err;
    logic [20:0] cp;
    logic [2:0]  len;
  } seg_t;

  // One queued job: the results of one input beat
  typedef struct packed {
    seg_t        seg0;
    seg_t        seg1;
    logic        two;    // seg1 follows seg0
    logic        eos;    // last result closes the string
    logic [15:0] base;   // byte count before the first segment
  } job_t;

  // Number of UTF-8 bytes for a code point
  function automatic logic [2:0] utf8_len(logic [20:0] cp);
    logic [2:0] n;
    if (cp < 21'h80) begin
      n = 3'd1;
    end else if (cp < 21'h800) begin
      n = 3'd2;
    end else if (cp < 21'h10000) begin
      n = 3'd3;
    end else begin
      n = 3'd4;
    end
    return n;
  endfunction

  // Byte idx of the UTF-8 encoding of cp, which is len bytes long
  function automatic logic [7:0] utf8_byte(logic [20:0] cp, logic [2:0] len,
                                           logic [1:0] idx);
    logic [1:0]  rem;
    logic [20:0] sh;
    logic [7:0]  b;
    rem = 2'(len - 3'd1 - {1'b0, idx});
    unique case (rem)
      2'd0: sh = cp;
      2'd1: sh = {6'b0, cp[20:6]};
      2'd2: sh = {12'b0, cp[20:12]};
      default: sh = {18'b0, cp[20:18]};
    endcase
    if (idx == 2'd0) begin
      unique case (len)
        3'd1: b = sh[7:0];
        3'd2: b = Lead2Mark | sh[7:0];
        3'd3: b = Lead3Mark | sh[7:0];
        default: b = Lead4Mark | sh[7:0];
      endcase
    end else begin
      b = ContMark | {2'b0, sh[5:0]};
    end
    return b;
  endfunction

endpackage

@@ design/u16u8_front.sv @@
// ---------------------------------------------------------------------------
// u16u8_front
// Accepts code units, pairs surrogates, checks capacity and turns each
// beat that has a result into a job of up to two segments for the back end.
// ---------------------------------------------------------------------------
module u16u8_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  u16u8_pkg::cfg_t   cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [15:0]       code_unit_i,
  input  logic              last_unit_i,
  input  logic              full_i,
  output logic              push_o,
  output u16u8_pkg::job_t   job_o
);
  import u16u8_pkg::*;

  // String state
  logic        pend_q, pend_d;
  logic [9:0]  held_q, held_d;
  logic [15:0] bw_q, bw_d;
  logic        disc_q, disc_d;

  logic        accept;
  logic        is_high, is_low;
  logic [20:0] cp_pair, cp_held;
  logic [2:0]  u_len;
  seg_t        seg_a, seg_b;
  logic        a_vld, b_vld;
  logic        fail, hold;
  logic [15:0] bw_a, bw_b;

  // Does a code point of n bytes still fit?
  function automatic logic fits(logic [15:0] bw, logic [2:0] n, logic [15:0] cap);
    return ({1'b0, bw} + {14'b0, n}) <= {1'b0, cap};
  endfunction

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  assign is_high = code_unit_i[15:10] == HighSurrTag;
  assign is_low  = code_unit_i[15:10] == LowSurrTag;
  assign cp_pair = SuppBase + {1'b0, held_q, code_unit_i[9:0]};
  assign cp_held = {5'b0, HighSurrTag, held_q};
  assign u_len   = utf8_len({5'b0, code_unit_i});

  // Classify the beat into a held-surrogate segment and a new-unit segment
  always_comb begin
    seg_a = '0;
    seg_b = '0;
    a_vld = 1'b0;
    b_vld = 1'b0;
    fail  = 1'b0;
    hold  = 1'b0;
    bw_a  = bw_q;
    bw_b  = bw_q;
    if (!disc_q) begin
      if (pend_q && is_low) begin
        a_vld     = 1'b1;
        seg_a.cp  = cp_pair;
        seg_a.len = 3'd4;
        if (fits(bw_q, 3'd4, cfg_i.capacity)) begin
          bw_a = bw_q + 16'd4;
        end else begin
          seg_a.is_err = 1'b1;
          seg_a.err    = ERR_FULL;
          fail         = 1'b1;
        end
        bw_b = bw_a;
      end else begin
        // held high surrogate with no partner
        if (pend_q) begin
          a_vld = 1'b1;
          if (cfg_i.strict) begin
            seg_a.is_err = 1'b1;
            seg_a.err    = ERR_INVALID;
            fail         = 1'b1;
          end else begin
            seg_a.cp  = cp_held;
            seg_a.len = 3'd3;
            if (fits(bw_q, 3'd3, cfg_i.capacity)) begin
              bw_a = bw_q + 16'd3;
            end else begin
              seg_a.is_err = 1'b1;
              seg_a.err    = ERR_FULL;
              fail         = 1'b1;
            end
          end
        end
        bw_b = bw_a;
        // the new unit itself
        if (!fail) begin
          if (is_high) begin
            if (last_unit_i) begin
              b_vld        = 1'b1;
              seg_b.is_err = 1'b1;
              seg_b.err    = ERR_TRUNC;
              fail         = 1'b1;
            end else begin
              hold = 1'b1;
            end
          end else if (is_low && cfg_i.strict) begin
            b_vld        = 1'b1;
            seg_b.is_err = 1'b1;
            seg_b.err    = ERR_INVALID;
            fail         = 1'b1;
          end else begin
            b_vld     = 1'b1;
            seg_b.cp  = {5'b0, code_unit_i};
            seg_b.len = u_len;
            if (fits(bw_a, u_len, cfg_i.capacity)) begin
              bw_b = bw_a + {13'b0, u_len};
            end else begin
              seg_b.is_err = 1'b1;
              seg_b.err    = ERR_FULL;
              fail         = 1'b1;
            end
          end
        end
      end
    end
  end

  // Pack the job, first present segment in seg0
  always_comb begin
    job_o.seg0 = a_vld ? seg_a : seg_b;
    job_o.seg1 = seg_b;
    job_o.two  = a_vld && b_vld;
    job_o.eos  = fail || last_unit_i;
    job_o.base = bw_q;
  end

  assign push_o = accept && !disc_q && (a_vld || b_vld);

  // Next string state
  always_comb begin
    pend_d = pend_q;
    held_d = held_q;
    bw_d   = bw_q;
    disc_d = disc_q;
    if (accept) begin
      if (disc_q) begin
        if (last_unit_i) begin
          disc_d = 1'b0;
          bw_d   = '0;
        end
      end else if (fail) begin
        pend_d = 1'b0;
        held_d = '0;
        bw_d   = last_unit_i ? 16'd0 : bw_b;
        disc_d = !last_unit_i;
      end else if (last_unit_i) begin
        pend_d = 1'b0;
        held_d = '0;
        bw_d   = '0;
      end else begin
        pend_d = hold;
        held_d = hold ? code_unit_i[9:0] : 10'd0;
        bw_d   = bw_b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      held_q <= '0;
      bw_q   <= '0;
      disc_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      held_q <= held_d;
      bw_q   <= bw_d;
      disc_q <= disc_d;
    end
  end

endmodule

@@ design/u16u8_fifo.sv @@
// ---------------------------------------------------------------------------
// u16u8_fifo
// Short job queue between front and back, head readable every cycle.
// ---------------------------------------------------------------------------
module u16u8_fifo #(
  parameter int unsigned DEPTH = u16u8_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  u16u8_pkg::job_t   wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output u16u8_pkg::job_t   rdata_o
);
  import u16u8_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  job_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] bump(logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = cnt_q == CntW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rd_q];

  // Pointer and fill update
  always_comb begin
    wr_d  = push_i ? bump(wr_q) : wr_q;
    rd_d  = pop_i ? bump(rd_q) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

@@ design/u16u8_back.sv @@
// ---------------------------------------------------------------------------
// u16u8_back
// Walks queued jobs one UTF-8 byte per unstalled cycle into the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module u16u8_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  u16u8_pkg::job_t   job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic              last_of_run_o,
  output logic              end_of_string_o,
  output logic [1:0]        error_code_o,
  output logic [15:0]       byte_count_o
);
  import u16u8_pkg::*;

  // Sequencer position inside the head job
  logic        seg_q, seg_d;
  logic [1:0]  idx_q, idx_d;
  logic [15:0] cnt_q, cnt_d;

  // Output register
  logic        vld_q, vld_d;
  logic [7:0]  byte_q;
  logic        lor_q, eos_q;
  err_e        err_q;
  logic [15:0] bcnt_q;

  logic        advance, fire, first, seg_end, job_end;
  seg_t        cur;
  logic [15:0] cur_cnt, cnt_out;
  logic [7:0]  byte_out;

  assign advance = !vld_q || !out_stall_i;
  assign fire    = advance && !empty_i;
  assign cur     = seg_q ? job_i.seg1 : job_i.seg0;
  assign first   = !seg_q && (idx_q == 2'd0);
  assign cur_cnt = first ? job_i.base : cnt_q;
  assign seg_end = cur.is_err || ({1'b0, idx_q} == (cur.len - 3'd1));
  assign job_end = seg_end && (seg_q || !job_i.two);
  assign pop_o   = fire && job_end;

  // Byte and count of this beat; an error beat writes nothing
  assign byte_out = cur.is_err ? 8'h00 : utf8_byte(cur.cp, cur.len, idx_q);
  assign cnt_out  = cur.is_err ? cur_cnt : cur_cnt + 16'd1;

  // Sequencer step
  always_comb begin
    seg_d = seg_q;
    idx_d = idx_q;
    cnt_d = cnt_q;
    vld_d = vld_q;
    if (fire) begin
      vld_d = 1'b1;
      cnt_d = cnt_out;
      if (seg_end) begin
        idx_d = '0;
        seg_d = !job_end;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end else if (advance) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= 1'b0;
      idx_q <= '0;
      cnt_q <= '0;
      vld_q <= 1'b0;
    end else begin
      seg_q <= seg_d;
      idx_q <= idx_d;
      cnt_q <= cnt_d;
      vld_q <= vld_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      byte_q <= byte_out;
      lor_q  <= job_end;
      eos_q  <= job_end && job_i.eos;
      err_q  <= cur.is_err ? cur.err : ERR_NONE;
      bcnt_q <= cnt_out;
    end
  end

  assign out_valid_o     = vld_q;
  assign out_byte_o      = byte_q;
  assign last_of_run_o   = lor_q;
  assign end_of_string_o = eos_q;
  assign error_code_o    = err_q;
  assign byte_count_o    = bcnt_q;

  // An error beat is a zero byte that closes both the run and the string
  `ASSERT_RST(a_err_closes, (vld_q && err_q != ERR_NONE) |-> (byte_q == 8'h00 && lor_q && eos_q), "error beat not closing")
  // End of string is always the final beat of its run
  `ASSERT_RST(a_eos_lor, (vld_q && eos_q) |-> lor_q, "end of string without end of run")
  // Retiring a job leaves its final beat in the output register
  `ASSERT_RST(a_pop_last, pop_o |=> (vld_q && lor_q), "job retired without final beat")

endmodule

@@ design/utf16_to_utf8_converter.sv @@
// ---------------------------------------------------------------------------
// utf16_to_utf8_converter
// UTF-16 to UTF-8 transcoder: one code unit in per beat, one UTF-8 byte
// (or an error beat) out per beat.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+----------------------------------------
//   input    | in_valid_i/in_stall_o | code_unit_i, last_unit_i
//   output   | out_valid_o/out_stall_i | out_byte_o, last_of_run_o,
//            |                       | end_of_string_o, error_code_o,
//            |                       | byte_count_o
//   config   | cfg_we_i              | cfg_index_i, cfg_wdata_i
//
// The front takes one code unit per cycle while the job queue has room.
// The back emits one byte per cycle while out_stall_i is low; a unit causes
// 0 bytes for a held high surrogate or a discarded unit, 1 to 3 for a
// plain unit, 4 for a pair, up to 6 when a held surrogate is flushed.
// Reset is asynchronous, needs no clearing pass; control registers take their
// reset values at once. Output stalls fill the queue, then stall the input.
// ---------------------------------------------------------------------------
module utf16_to_utf8_converter #(
  parameter int unsigned QUEUE_DEPTH = u16u8_pkg::QueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [15:0]                   code_unit_i,
  input  logic                          last_unit_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    out_byte_o,
  output logic                          last_of_run_o,
  output logic                          end_of_string_o,
  output logic [1:0]                    error_code_o,
  output logic [15:0]                   byte_count_o,
  input  logic                          cfg_we_i,
  input  logic [u16u8_pkg::RegIdxW-1:0] cfg_index_i,
  input  logic [15:0]                   cfg_wdata_i
);
  import u16u8_pkg::*;

  logic        strict_q;
  logic [15:0] cap_q;
  cfg_t        cfg;
  logic        push, pop, full, empty;
  job_t        wjob, rjob;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strict_q <= StrictReset;
      cap_q    <= CapacityReset;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_STRICT_MODE:     strict_q <= cfg_wdata_i[0];
        REG_OUTPUT_CAPACITY: cap_q    <= cfg_wdata_i;
      endcase
    end
  end

  assign cfg.strict   = strict_q;
  assign cfg.capacity = cap_q;

  u16u8_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .code_unit_i (code_unit_i),
    .last_unit_i (last_unit_i),
    .full_i      (full),
    .push_o      (push),
    .job_o       (wjob)
  );

  u16u8_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wjob),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (rjob)
  );

  u16u8_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .job_i           (rjob),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .last_of_run_o   (last_of_run_o),
    .end_of_string_o (end_of_string_o),
    .error_code_o    (error_code_o),
    .byte_count_o    (byte_count_o)
  );

endmodule
